// ----- hdl/slbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial-loaded bank mapper package
// Types, constants and the field widths shared by the mapper modules.
// ----------------------------------------------------------------------------
package slbm_pkg;

    localparam int PRG_BANK_W = 5;
    localparam int CHR_BANK_W = 7;
    localparam int SHIFT_W    = 5;
    localparam int COUNT_W    = 5;

    // The marker bit sits at the top of an empty shifter and walks down.
    localparam logic [SHIFT_W-1:0]    SHIFT_MARK     = 5'h10;
    localparam logic [SHIFT_W-1:0]    RESET_OR       = 5'h0C;
    localparam logic [COUNT_W-1:0]    COUNT_RESET    = 5'd16;
    localparam logic [PRG_BANK_W-1:0] PRG_LAST_ADJ   = 5'd30;
    localparam logic [PRG_BANK_W-1:0] PRG_HIGH_RESET = 5'd30;
    localparam logic [CHR_BANK_W-1:0] CHR_HIGH_RESET = 7'd4;

    typedef enum logic [1:0] {
        TGT_CONTROL = 2'd0,
        TGT_CHR0    = 2'd1,
        TGT_CHR1    = 2'd2,
        TGT_PRG     = 2'd3
    } t_target;

    typedef enum logic [1:0] {
        PRG_MODE_32K_A    = 2'd0,
        PRG_MODE_32K_B    = 2'd1,
        PRG_MODE_FIX_LOW  = 2'd2,
        PRG_MODE_FIX_HIGH = 2'd3
    } t_prg_mode;

    typedef struct packed {
        logic [SHIFT_W-1:0]    shift;
        logic [SHIFT_W-1:0]    control;
        logic [PRG_BANK_W-1:0] prg_low;
        logic [PRG_BANK_W-1:0] prg_high;
        logic [CHR_BANK_W-1:0] chr_low;
        logic [CHR_BANK_W-1:0] chr_high;
    } t_map_state;

    typedef struct packed {
        logic [1:0]            mirroring;
        logic [PRG_BANK_W-1:0] prg_low_bank;
        logic [PRG_BANK_W-1:0] prg_high_bank;
        logic [CHR_BANK_W-1:0] chr_low_bank;
        logic [CHR_BANK_W-1:0] chr_high_bank;
        logic                  committed;
    } t_result;

endpackage

// ----- hdl/serial_loaded_bank_mapper_core.sv -----
// ----------------------------------------------------------------------------
// Serial-loaded bank mapper core
// Five-write serial register loading with PRG and CHR bank slot mapping.
// ----------------------------------------------------------------------------
// Each CPU write transfer is applied to the mapper state in the cycle it is
// accepted; its report is registered in the output register or skid stage.
// One write can be accepted every cycle; the block only stalls its input
// when both the output register and its skid stage hold reports that the
// consumer has not yet taken. The PRG bank count is set through the
// configuration port and takes effect at the next PRG load in fixed-last
// mode; write it only while no transfer is in flight.
module serial_loaded_bank_mapper_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [slbm_pkg::COUNT_W-1:0]      i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [15:0]                       i_address,
    input  logic [7:0]                        i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_mirroring,
    output logic [slbm_pkg::PRG_BANK_W-1:0]   o_prg_low_bank,
    output logic [slbm_pkg::PRG_BANK_W-1:0]   o_prg_high_bank,
    output logic [slbm_pkg::CHR_BANK_W-1:0]   o_chr_low_bank,
    output logic [slbm_pkg::CHR_BANK_W-1:0]   o_chr_high_bank,
    output logic                              o_committed
);

    slbm_pkg::t_map_state           r_state;
    slbm_pkg::t_map_state           n_state;
    logic [slbm_pkg::COUNT_W-1:0]   r_count;
    slbm_pkg::t_result              next_result;
    slbm_pkg::t_result              out_result;
    logic                           buf_full;
    logic                           accept;

    assign accept  = i_valid && !buf_full;
    assign o_stall = buf_full;

    slbm_update u_update (
        .i_state   (r_state),
        .i_count   (r_count),
        .i_address (i_address),
        .i_value   (i_value),
        .o_state   (n_state),
        .o_result  (next_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count          <= slbm_pkg::COUNT_RESET;
            r_state.shift    <= slbm_pkg::SHIFT_MARK;
            r_state.control  <= '0;
            r_state.prg_low  <= '0;
            r_state.prg_high <= slbm_pkg::PRG_HIGH_RESET;
            r_state.chr_low  <= '0;
            r_state.chr_high <= slbm_pkg::CHR_HIGH_RESET;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (accept) begin
                r_state <= n_state;
            end
        end
    end

    slbm_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (next_result),
        .o_full   (buf_full),
        .o_valid  (o_valid),
        .o_result (out_result),
        .i_stall  (i_stall)
    );

    assign o_mirroring     = out_result.mirroring;
    assign o_prg_low_bank  = out_result.prg_low_bank;
    assign o_prg_high_bank = out_result.prg_high_bank;
    assign o_chr_low_bank  = out_result.chr_low_bank;
    assign o_chr_high_bank = out_result.chr_high_bank;
    assign o_committed     = out_result.committed;

    // The marker bit is never lost, so the shifter can never read as zero.
    a_shift_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.shift != '0)
        else $error("serial shifter lost its marker bit");

    // A reset byte empties the shifter and forces fixed-last PRG mode.
    a_reset_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_value[7] |=> r_state.shift == slbm_pkg::SHIFT_MARK &&
        r_state.control[3:2] == 2'b11)
        else $error("reset byte did not clear the shifter");

    // A completed load always leaves the shifter empty again.
    a_commit_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && next_result.committed |=> r_state.shift == slbm_pkg::SHIFT_MARK)
        else $error("shifter not emptied after a load");

    // The skid stage only fills behind a held output report.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid stage full while output register empty");

    // The state changes only on an accepted transfer.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_state))
        else $error("mapper state changed without a transfer");

endmodule

// ----- hdl/slbm_update.sv -----
// ----------------------------------------------------------------------------
// Mapper state update
// Applies one CPU write to the mapper state and forms the mapping report.
// ----------------------------------------------------------------------------
module slbm_update (
    input  slbm_pkg::t_map_state               i_state,
    input  logic [slbm_pkg::COUNT_W-1:0]       i_count,
    input  logic [15:0]                        i_address,
    input  logic [7:0]                         i_value,
    output slbm_pkg::t_map_state               o_state,
    output slbm_pkg::t_result                  o_result
);

    slbm_pkg::t_target            target;
    logic [slbm_pkg::SHIFT_W-1:0] shifted;
    logic [slbm_pkg::PRG_BANK_W-1:0] last_pair;
    logic                         done;

    assign target    = slbm_pkg::t_target'(i_address[14:13]);
    assign shifted   = {i_value[0], i_state.shift[slbm_pkg::SHIFT_W-1:1]};
    // Twice the 16K bank count, minus two, wrapped to the bank width.
    assign last_pair = {i_count[3:0], 1'b0} + slbm_pkg::PRG_LAST_ADJ;

    always_comb begin
        o_state = i_state;
        done    = 1'b0;
        if (i_value[7]) begin
            o_state.shift   = slbm_pkg::SHIFT_MARK;
            o_state.control = i_state.control | slbm_pkg::RESET_OR;
        end else if (!i_state.shift[0]) begin
            o_state.shift = shifted;
        end else begin
            // Fifth bit: the marker has reached bit 0, so load the target.
            o_state.shift = slbm_pkg::SHIFT_MARK;
            done          = 1'b1;
            case (target)
                slbm_pkg::TGT_CONTROL: begin
                    o_state.control = shifted;
                end
                slbm_pkg::TGT_CHR0: begin
                    if (!i_state.control[4]) begin
                        o_state.chr_low  = {shifted[4:1], 3'b000};
                        o_state.chr_high = {shifted[4:1], 3'b100};
                    end else begin
                        o_state.chr_low = {shifted, 2'b00};
                    end
                end
                slbm_pkg::TGT_CHR1: begin
                    if (i_state.control[4]) begin
                        o_state.chr_high = {shifted, 2'b00};
                    end
                end
                slbm_pkg::TGT_PRG: begin
                    case (slbm_pkg::t_prg_mode'(i_state.control[3:2]))
                        slbm_pkg::PRG_MODE_32K_A,
                        slbm_pkg::PRG_MODE_32K_B: begin
                            o_state.prg_low  = {shifted[3:1], 2'b00};
                            o_state.prg_high = {shifted[3:1], 2'b10};
                        end
                        slbm_pkg::PRG_MODE_FIX_LOW: begin
                            o_state.prg_low  = '0;
                            o_state.prg_high = {shifted[3:0], 1'b0};
                        end
                        default: begin
                            o_state.prg_low  = {shifted[3:0], 1'b0};
                            o_state.prg_high = last_pair;
                        end
                    endcase
                end
                default: begin
                    o_state.control = i_state.control;
                end
            endcase
        end
    end

    assign o_result.mirroring     = o_state.control[1:0];
    assign o_result.prg_low_bank  = o_state.prg_low;
    assign o_result.prg_high_bank = o_state.prg_high;
    assign o_result.chr_low_bank  = o_state.chr_low;
    assign o_result.chr_high_bank = o_state.chr_high;
    assign o_result.committed     = done;

endmodule

// ----- hdl/slbm_out_buf.sv -----
// ----------------------------------------------------------------------------
// Mapper result buffer
// Output register with a skid stage, so that a write can be taken in the
// cycle where a finished report is still stalled.
// ----------------------------------------------------------------------------
module slbm_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  slbm_pkg::t_result  i_result,
    output logic               o_full,
    output logic               o_valid,
    output slbm_pkg::t_result  o_result,
    input  logic               i_stall
);

    logic              r_out_valid;
    logic              r_skid_valid;
    slbm_pkg::t_result r_out;
    slbm_pkg::t_result r_skid;
    logic              n_out_valid;
    logic              n_skid_valid;
    slbm_pkg::t_result n_out;
    slbm_pkg::t_result n_skid;
    logic              take;

    assign take = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_load) begin
            if (!r_out_valid || take) begin
                n_out       = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
